// ===== sv/mchw_pkg.sv =====
// ----------------------------------------------------------------------------
// mchw_pkg: shared types and constants for the heartbeat watchdog
// Field widths, health codes, opcodes, register indexes and the word structs.
// ----------------------------------------------------------------------------
package mchw_pkg;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned ChBits      = 4;
  localparam int unsigned CntBits     = 5;
  localparam int unsigned TimeBits    = 20;
  localparam int unsigned SumBits     = 24;

  localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

  typedef enum logic [1:0] {
    HEALTH_OK       = 2'd0,
    HEALTH_WARNING  = 2'd1,
    HEALTH_CRITICAL = 2'd2,
    HEALTH_DEAD     = 2'd3
  } health_e;

  typedef enum logic [1:0] {
    OP_HEARTBEAT = 2'd0,
    OP_SCAN      = 2'd1,
    OP_REPORT    = 2'd2,
    OP_QUERY     = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    REG_CHANNELS  = 3'd0,
    REG_WARN_TIME = 3'd1,
    REG_CRIT_TIME = 3'd2,
    REG_MAX_SKIP  = 3'd3,
    REG_DEAD_LIM  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TALLY,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [ChBits-1:0]   channel_index;
    logic [31:0]         frame_number;
    logic [TimeBits-1:0] update_time;
  } in_word_t;

  typedef struct packed {
    logic                channel_found;
    logic [1:0]          channel_health;
    logic [CntBits-1:0]  count_ok;
    logic [CntBits-1:0]  count_warning;
    logic [CntBits-1:0]  count_critical;
    logic [CntBits-1:0]  count_dead;
    logic [TimeBits-1:0] peak_time;
    logic [SumBits-1:0]  sum_time;
    logic                all_healthy;
    logic [31:0]         critical_events;
    logic [31:0]         warning_events;
    logic [31:0]         recovery_events;
  } out_word_t;

endpackage

// ===== sv/multi_channel_heartbeat_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog: health table for sixteen channels
// Heartbeat, scan, report and query words over one shared per-entry datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid_i/in_stall_o carry one command word (opcode, channel, frame,
//   update time). out_valid_o/out_stall_i carry one result word per command.
//   The config channel (cfg_valid_i/cfg_ready_o, index, data) writes the five
//   registers; write only while the block is idle. Writing the channel count
//   clears every entry at or above the new count in that cycle.
// Timing:
//   A heartbeat is applied in the accept cycle. A scan then walks the
//   entries one per cycle through one shared age compare and peak
//   compare; every command then walks the table once more through one
//   shared adder to build the totals, and the result word is then
//   registered. One command is in flight at a time: a new command is
//   taken only once the last result has been taken.
// Reset:
//   All entries, totals and counters clear; registers take their defaults.
// Stall:
//   The result is held in the output register until taken; the next
//   command is accepted no earlier than the cycle after the result leaves.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mchw_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mchw_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned N  = mchw_pkg::MaxChannels;
  localparam int unsigned CB = mchw_pkg::ChBits;
  localparam int unsigned TB = mchw_pkg::TimeBits;

  // registers
  logic [4:0]    chans_q;
  logic [TB-1:0] warn_q, crit_q;
  logic [15:0]   skip_q, dead_q;

  // table
  logic [N-1:0]  init_q;
  logic [31:0]   lframe_q [N];
  logic [TB-1:0] ltime_q  [N];
  logic [1:0]    health_q [N];
  logic [15:0]   late_q   [N];
  logic [15:0]   ccnt_q   [N];

  logic [31:0]   frame_q, ctot_q, wtot_q, rtot_q, stot_q;
  logic [TB-1:0] peak_q;

  // sequencer
  mchw_pkg::state_e state_q, state_d;
  logic [CB:0]        idx_q;
  mchw_pkg::in_word_t cmd_q;
  logic [4:0]         cnt_q [4];
  logic [mchw_pkg::SumBits-1:0] sum_q;
  logic               oval_q;
  mchw_pkg::out_word_t odata_q;

  logic [4:0] n_act;
  logic       accept, take_out, cfg_wr;
  logic [CB-1:0] ci;
  logic [CB-1:0] wi;
  logic       in_range;

  assign n_act    = (chans_q > 5'(N)) ? 5'(N) : chans_q;
  assign accept   = in_valid_i && !in_stall_o;
  assign take_out = oval_q && !out_stall_i;
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;
  assign ci       = in_data_i.channel_index;
  assign wi       = idx_q[CB-1:0];
  assign in_range = idx_q < n_act;

  assign in_stall_o  = (state_q != mchw_pkg::ST_IDLE) || oval_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;

  // shared per-entry datapath: age, peak and sum
  logic [31:0]   age;
  logic          stale;
  logic [15:0]   ccnt_inc;
  logic [mchw_pkg::SumBits:0] sum_add;

  assign age      = frame_q - lframe_q[wi];
  assign stale    = age > {16'd0, skip_q};
  assign ccnt_inc = (ccnt_q[wi] == 16'hFFFF) ? ccnt_q[wi] : ccnt_q[wi] + 16'd1;
  assign sum_add  = {1'b0, sum_q} + (mchw_pkg::SumBits+1)'(ltime_q[wi]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mchw_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.opcode == mchw_pkg::OP_SCAN) ? mchw_pkg::ST_SCAN
                                                            : mchw_pkg::ST_TALLY;
        end
      end
      mchw_pkg::ST_SCAN:  if (idx_q == (CB+1)'(N-1)) state_d = mchw_pkg::ST_TALLY;
      mchw_pkg::ST_TALLY: if (idx_q == (CB+1)'(N-1)) state_d = mchw_pkg::ST_OUT;
      mchw_pkg::ST_OUT:   state_d = mchw_pkg::ST_IDLE;
      default:            state_d = mchw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mchw_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // configuration, table and sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q <= '0;
      warn_q  <= TB'(16000);
      crit_q  <= TB'(33000);
      skip_q  <= 16'd60;
      dead_q  <= 16'd3;
      init_q  <= '0;
      for (int i = 0; i < N; i++) begin
        lframe_q[i] <= '0;
        ltime_q[i]  <= '0;
        health_q[i] <= mchw_pkg::HEALTH_OK;
        late_q[i]   <= '0;
        ccnt_q[i]   <= '0;
      end
      frame_q <= '0; ctot_q <= '0; wtot_q <= '0; rtot_q <= '0; stot_q <= '0;
      peak_q  <= '0;
      idx_q   <= '0;
      cmd_q   <= '0;
      for (int k = 0; k < 4; k++) cnt_q[k] <= '0;
      sum_q   <= '0;
      oval_q  <= 1'b0;
      odata_q <= '0;
    end else begin
      if (take_out) oval_q <= 1'b0;

      if (cfg_wr) begin
        case (cfg_index_i)
          mchw_pkg::REG_CHANNELS: begin
            chans_q <= cfg_data_i[4:0];
            for (int i = 0; i < N; i++) begin
              if (5'(i) >= ((cfg_data_i[4:0] > 5'(N)) ? 5'(N) : cfg_data_i[4:0])) begin
                init_q[i]   <= 1'b0;
                lframe_q[i] <= '0;
                ltime_q[i]  <= '0;
                health_q[i] <= mchw_pkg::HEALTH_OK;
                late_q[i]   <= '0;
                ccnt_q[i]   <= '0;
              end
            end
          end
          mchw_pkg::REG_WARN_TIME: warn_q <= cfg_data_i[TB-1:0];
          mchw_pkg::REG_CRIT_TIME: crit_q <= cfg_data_i[TB-1:0];
          mchw_pkg::REG_MAX_SKIP:  skip_q <= cfg_data_i[15:0];
          mchw_pkg::REG_DEAD_LIM:  dead_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      case (state_q)
        mchw_pkg::ST_IDLE: begin
          if (accept) begin
            cmd_q <= in_data_i;
            idx_q <= '0;
            sum_q <= '0;
            for (int k = 0; k < 4; k++) cnt_q[k] <= '0;
            if (in_data_i.opcode == mchw_pkg::OP_SCAN) begin
              stot_q  <= (stot_q == '1) ? stot_q : stot_q + 32'd1;
              frame_q <= frame_q + 32'd1;
              peak_q  <= '0;
            end
            // heartbeat applied at once
            if (in_data_i.opcode == mchw_pkg::OP_HEARTBEAT &&
                {1'b0, ci} < n_act) begin
              init_q[ci]   <= 1'b1;
              lframe_q[ci] <= in_data_i.frame_number;
              ltime_q[ci]  <= in_data_i.update_time;
              if (in_data_i.frame_number <= lframe_q[ci] && late_q[ci] != 16'hFFFF)
                late_q[ci] <= late_q[ci] + 16'd1;
              if (in_data_i.update_time > crit_q) begin
                health_q[ci] <= mchw_pkg::HEALTH_CRITICAL;
                if (ccnt_q[ci] != 16'hFFFF) ccnt_q[ci] <= ccnt_q[ci] + 16'd1;
                if (ctot_q != '1) ctot_q <= ctot_q + 32'd1;
              end else if (in_data_i.update_time > warn_q) begin
                health_q[ci] <= mchw_pkg::HEALTH_WARNING;
                if (wtot_q != '1) wtot_q <= wtot_q + 32'd1;
              end else begin
                if ((health_q[ci] == mchw_pkg::HEALTH_WARNING ||
                     health_q[ci] == mchw_pkg::HEALTH_CRITICAL) && rtot_q != '1)
                  rtot_q <= rtot_q + 32'd1;
                health_q[ci] <= mchw_pkg::HEALTH_OK;
              end
            end
          end
        end
        mchw_pkg::ST_SCAN: begin
          // one entry per cycle
          if (in_range && init_q[wi]) begin
            if (ltime_q[wi] > peak_q) peak_q <= ltime_q[wi];
            if (stale) begin
              ccnt_q[wi]   <= ccnt_inc;
              if (ctot_q != '1) ctot_q <= ctot_q + 32'd1;
              health_q[wi] <= ({16'd0, ccnt_inc} > {16'd0, dead_q}) ?
                              mchw_pkg::HEALTH_DEAD : mchw_pkg::HEALTH_CRITICAL;
            end
          end
          idx_q <= (idx_q == (CB+1)'(N-1)) ? '0 : idx_q + 1'b1;
        end
        mchw_pkg::ST_TALLY: begin
          if (in_range) begin
            cnt_q[health_q[wi]] <= cnt_q[health_q[wi]] + 5'd1;
            sum_q <= (sum_add > {1'b0, mchw_pkg::SumMax}) ? mchw_pkg::SumMax
                                                          : sum_add[mchw_pkg::SumBits-1:0];
          end
          idx_q <= idx_q + 1'b1;
        end
        mchw_pkg::ST_OUT: begin
          oval_q <= 1'b1;
          odata_q.channel_found   <= {1'b0, cmd_q.channel_index} < n_act;
          odata_q.channel_health  <= ({1'b0, cmd_q.channel_index} < n_act) ?
                                     health_q[cmd_q.channel_index] : 2'd0;
          odata_q.count_ok        <= cnt_q[mchw_pkg::HEALTH_OK];
          odata_q.count_warning   <= cnt_q[mchw_pkg::HEALTH_WARNING];
          odata_q.count_critical  <= cnt_q[mchw_pkg::HEALTH_CRITICAL];
          odata_q.count_dead      <= cnt_q[mchw_pkg::HEALTH_DEAD];
          odata_q.peak_time       <= peak_q;
          odata_q.sum_time        <= sum_q;
          odata_q.all_healthy     <= (cnt_q[mchw_pkg::HEALTH_CRITICAL] == '0) &&
                                     (cnt_q[mchw_pkg::HEALTH_DEAD] == '0);
          odata_q.critical_events <= ctot_q;
          odata_q.warning_events  <= wtot_q;
          odata_q.recovery_events <= rtot_q;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mchw_checker.sv =====
// ----------------------------------------------------------------------------
// mchw_checker: port-level checks for the heartbeat watchdog
// Watches the command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module mchw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mchw_pkg::out_word_t out_data_o
);

  // a result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");

  // no command taken while a result waits
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("command taken while result pending");

  // a result never follows its command in the next cycle
  a_min_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // health counts never exceed sixteen in total
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (7'(out_data_o.count_ok) + 7'(out_data_o.count_warning) +
                     7'(out_data_o.count_critical) + 7'(out_data_o.count_dead)) <= 7'd16)
    else $error("health counts out of range");

endmodule

bind multi_channel_heartbeat_watchdog mchw_checker u_mchw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the multi-channel heartbeat watchdog
// Drives heartbeat, scan, report and query words under random idling and
// stalls, predicts every result word from a local model of the health table
// and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumCh      = mchw_pkg::MaxChannels;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  mchw_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  mchw_pkg::out_word_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [31:0]         cfg_data;

  multi_channel_heartbeat_watchdog u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // predictor state: registers and the health table
  logic [4:0]          n_chan;
  logic [19:0]         warn_thr, crit_thr;
  logic [15:0]         skip_lim, dead_lim;
  logic                ch_init [NumCh];
  logic                ch_resp [NumCh];
  logic [31:0]         ch_frame[NumCh];
  logic [19:0]         ch_time [NumCh];
  mchw_pkg::health_e   ch_health[NumCh];
  logic [15:0]         ch_late [NumCh];
  logic [15:0]         ch_crit [NumCh];
  logic [31:0]         frame_ctr, crit_tot, warn_tot, recov_tot, scan_tot;
  logic [19:0]         peak_val;

  mchw_pkg::in_word_t  cmd_queue[$];
  mchw_pkg::out_word_t health_expect[$];
  int        errors = 0;
  int        results_seen = 0;
  int        cycles = 0;
  int        hold_cnt = 0;
  bit        hold_used = 0;
  bit        hold_req = 0;

  function automatic logic [31:0] sat32(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic int live_count();
    return (n_chan > NumCh) ? NumCh : n_chan;
  endfunction

  function automatic void wipe_entry(int i);
    ch_init[i] = 0; ch_resp[i] = 1; ch_frame[i] = 0; ch_time[i] = 0;
    ch_health[i] = mchw_pkg::HEALTH_OK; ch_late[i] = 0; ch_crit[i] = 0;
  endfunction

  function automatic void reset_table();
    n_chan = 0; warn_thr = 16000; crit_thr = 33000; skip_lim = 60; dead_lim = 3;
    for (int i = 0; i < NumCh; i++) wipe_entry(i);
    frame_ctr = 0; peak_val = 0; crit_tot = 0; warn_tot = 0; recov_tot = 0;
    scan_tot = 0;
  endfunction

  function automatic void apply_reg(mchw_pkg::reg_idx_e idx, logic [31:0] v);
    case (idx)
      mchw_pkg::REG_CHANNELS: begin
        n_chan = v[4:0];
        for (int i = live_count(); i < NumCh; i++) wipe_entry(i);
      end
      mchw_pkg::REG_WARN_TIME: warn_thr = v[19:0];
      mchw_pkg::REG_CRIT_TIME: crit_thr = v[19:0];
      mchw_pkg::REG_MAX_SKIP:  skip_lim = v[15:0];
      mchw_pkg::REG_DEAD_LIM:  dead_lim = v[15:0];
      default: ;
    endcase
  endfunction

  // update the table for one command and build its result word
  function automatic mchw_pkg::out_word_t predict_health(mchw_pkg::in_word_t w);
    mchw_pkg::out_word_t r;
    int        n;
    int        cnt[4];
    logic [24:0] sum;
    logic [31:0] age;
    logic      hit;
    int        c;
    n = live_count();
    c = w.channel_index;
    hit = (c < n);
    cnt = '{0, 0, 0, 0};
    sum = 0;
    if (w.opcode == mchw_pkg::OP_HEARTBEAT && hit) begin
      ch_init[c] = 1;
      ch_resp[c] = 1;
      if (w.frame_number <= ch_frame[c]) ch_late[c] = sat16(ch_late[c]);
      ch_frame[c] = w.frame_number;
      ch_time[c] = w.update_time;
      if (w.update_time > crit_thr) begin
        ch_health[c] = mchw_pkg::HEALTH_CRITICAL;
        ch_crit[c] = sat16(ch_crit[c]);
        crit_tot = sat32(crit_tot);
      end else if (w.update_time > warn_thr) begin
        ch_health[c] = mchw_pkg::HEALTH_WARNING;
        warn_tot = sat32(warn_tot);
      end else begin
        if (ch_health[c] == mchw_pkg::HEALTH_WARNING ||
            ch_health[c] == mchw_pkg::HEALTH_CRITICAL)
          recov_tot = sat32(recov_tot);
        ch_health[c] = mchw_pkg::HEALTH_OK;
      end
    end else if (w.opcode == mchw_pkg::OP_SCAN) begin
      scan_tot = sat32(scan_tot);
      frame_ctr = frame_ctr + 32'd1;
      peak_val = 0;
      for (int i = 0; i < n; i++) begin
        if (ch_init[i]) begin
          if (ch_time[i] > peak_val) peak_val = ch_time[i];
          age = frame_ctr - ch_frame[i];
          if (age > skip_lim) begin
            ch_resp[i] = 0;
            ch_crit[i] = sat16(ch_crit[i]);
            crit_tot = sat32(crit_tot);
            ch_health[i] = (ch_crit[i] > dead_lim) ? mchw_pkg::HEALTH_DEAD
                                                   : mchw_pkg::HEALTH_CRITICAL;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      cnt[ch_health[i]]++;
      sum = sum + 25'(ch_time[i]);
      if (sum > {1'b0, mchw_pkg::SumMax}) sum = {1'b0, mchw_pkg::SumMax};
    end
    r.channel_found   = hit;
    r.channel_health  = hit ? ch_health[c] : mchw_pkg::HEALTH_OK;
    r.count_ok        = 5'(cnt[mchw_pkg::HEALTH_OK]);
    r.count_warning   = 5'(cnt[mchw_pkg::HEALTH_WARNING]);
    r.count_critical  = 5'(cnt[mchw_pkg::HEALTH_CRITICAL]);
    r.count_dead      = 5'(cnt[mchw_pkg::HEALTH_DEAD]);
    r.peak_time       = peak_val;
    r.sum_time        = sum[23:0];
    r.all_healthy     = (cnt[mchw_pkg::HEALTH_CRITICAL] == 0 &&
                         cnt[mchw_pkg::HEALTH_DEAD] == 0);
    r.critical_events = crit_tot;
    r.warning_events  = warn_tot;
    r.recovery_events = recov_tot;
    return r;
  endfunction

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // long receiver hold-off, counted here once requested
  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_cnt  <= 300;
      hold_used <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // driver: presents queued words with random gaps
  int  send_gap = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data  <= '0;
      send_gap = 0;
    end else if (in_valid && !in_stall) begin
      health_expect.insert(health_expect.size(), predict_health(in_data));
      send_gap = $urandom_range(0, 3);
      if (send_gap == 0 && cmd_queue.size() > 0) begin
        in_data <= cmd_queue.pop_front();
      end else begin
        in_valid <= 0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap--;
      else if (cmd_queue.size() > 0) begin
        in_valid <= 1;
        in_data  <= cmd_queue.pop_front();
      end
    end
  end

  // monitor: random stalls, long hold-off on request, field compare
  int stall_gap = 0;
  always @(posedge clk or negedge rst_n) begin
    mchw_pkg::out_word_t e;
    if (!rst_n) begin
      out_stall <= 1;
      stall_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (health_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, out_data);
        end else begin
          e = health_expect.pop_front();
          if (out_data.channel_found !== e.channel_found ||
              out_data.channel_health !== e.channel_health ||
              out_data.count_ok !== e.count_ok ||
              out_data.count_warning !== e.count_warning ||
              out_data.count_critical !== e.count_critical ||
              out_data.count_dead !== e.count_dead ||
              out_data.peak_time !== e.peak_time ||
              out_data.sum_time !== e.sum_time ||
              out_data.all_healthy !== e.all_healthy ||
              out_data.critical_events !== e.critical_events ||
              out_data.warning_events !== e.warning_events ||
              out_data.recovery_events !== e.recovery_events) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
          end
        end
        stall_gap = $urandom_range(0, 3);
      end
      if (hold_cnt > 0) begin
        out_stall <= 1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic add_cmd(mchw_pkg::opcode_e op, int ch, logic [31:0] fr, logic [19:0] t);
    mchw_pkg::in_word_t w;
    w.opcode = op; w.channel_index = 4'(ch); w.frame_number = fr; w.update_time = t;
    cmd_queue.insert(cmd_queue.size(), w);
  endtask

  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid || health_expect.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(mchw_pkg::reg_idx_e idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // random traffic: heartbeats with mostly rising frames, scans, reports and queries
  task automatic random_phase(int count);
    int r;
    logic [31:0] fr;
    logic [19:0] t;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      fr = frame_ctr + 32'(k / 4) + 32'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) fr = $urandom();
      case ($urandom_range(0, 3))
        0: t = 20'($urandom_range(0, warn_thr));
        1: t = 20'($urandom());
        2: t = 20'(crit_thr + $urandom_range(0, 2) - 1);
        default: t = 20'(warn_thr + $urandom_range(0, 2) - 1);
      endcase
      if (r < 55) add_cmd(mchw_pkg::OP_HEARTBEAT, $urandom_range(0, 15), fr, t);
      else if (r < 80) add_cmd(mchw_pkg::OP_SCAN, $urandom_range(0, 15), $urandom(),
                               20'($urandom()));
      else if (r < 90) add_cmd(mchw_pkg::OP_REPORT, $urandom_range(0, 15), $urandom(),
                               20'($urandom()));
      else add_cmd(mchw_pkg::OP_QUERY, $urandom_range(0, 15), $urandom(),
                   20'($urandom()));
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_valid = 0; cfg_index = mchw_pkg::REG_CHANNELS; cfg_data = '0;
    reset_table();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: no channels, then all sixteen with edge values
    add_cmd(mchw_pkg::OP_HEARTBEAT, 0, 32'd5, 20'd100);
    add_cmd(mchw_pkg::OP_QUERY, 15, 32'hFFFF_FFFF, 20'hFFFFF);
    drain();
    write_reg(mchw_pkg::REG_CHANNELS, 31);
    write_reg(mchw_pkg::REG_MAX_SKIP, 2);
    write_reg(mchw_pkg::REG_DEAD_LIM, 0);
    add_cmd(mchw_pkg::OP_HEARTBEAT, 0, 32'd0, 20'd0);
    add_cmd(mchw_pkg::OP_HEARTBEAT, 0, 32'd0, 20'hFFFFF);
    add_cmd(mchw_pkg::OP_HEARTBEAT, 0, 32'd1, 20'd16001);
    add_cmd(mchw_pkg::OP_HEARTBEAT, 0, 32'd2, 20'd16000);
    add_cmd(mchw_pkg::OP_HEARTBEAT, 15, 32'hFFFF_FFFF, 20'd33000);
    add_cmd(mchw_pkg::OP_HEARTBEAT, 7, 32'hAAAA_5555, 20'hAAAAA);
    add_cmd(mchw_pkg::OP_HEARTBEAT, 8, 32'h5555_AAAA, 20'h55555);
    for (int i = 0; i < 16; i++) add_cmd(mchw_pkg::OP_HEARTBEAT, i, 32'd3, 20'hFFFFF);
    add_cmd(mchw_pkg::OP_SCAN, 0, 0, 0);
    add_cmd(mchw_pkg::OP_SCAN, 0, 0, 0);
    add_cmd(mchw_pkg::OP_SCAN, 0, 0, 0);
    add_cmd(mchw_pkg::OP_REPORT, 3, 0, 0);
    add_cmd(mchw_pkg::OP_QUERY, 15, 0, 0);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(mchw_pkg::REG_WARN_TIME, 16000);
                 write_reg(mchw_pkg::REG_CRIT_TIME, 33000);
                 write_reg(mchw_pkg::REG_MAX_SKIP, 8);
                 write_reg(mchw_pkg::REG_DEAD_LIM, 3);
                 write_reg(mchw_pkg::REG_CHANNELS, 16); end
        1: begin write_reg(mchw_pkg::REG_CHANNELS, 5);
                 write_reg(mchw_pkg::REG_WARN_TIME, 0);
                 write_reg(mchw_pkg::REG_CRIT_TIME, 20'hFFFFF); end
        2: begin write_reg(mchw_pkg::REG_CHANNELS, 12);
                 write_reg(mchw_pkg::REG_WARN_TIME, 20'hFFFFF);
                 write_reg(mchw_pkg::REG_CRIT_TIME, 0);
                 write_reg(mchw_pkg::REG_MAX_SKIP, 0);
                 write_reg(mchw_pkg::REG_DEAD_LIM, 16'hFFFF); end
        3: begin write_reg(mchw_pkg::REG_CHANNELS, 1);
                 write_reg(mchw_pkg::REG_WARN_TIME, 500000);
                 write_reg(mchw_pkg::REG_CRIT_TIME, 900000);
                 write_reg(mchw_pkg::REG_MAX_SKIP, 16'hFFFF);
                 write_reg(mchw_pkg::REG_DEAD_LIM, 1); end
        4: begin write_reg(mchw_pkg::REG_CHANNELS, 16);
                 write_reg(mchw_pkg::REG_MAX_SKIP, 3); end
        default: begin write_reg(mchw_pkg::REG_CHANNELS, 0);
                       write_reg(mchw_pkg::REG_CHANNELS, 17);
                       write_reg(mchw_pkg::REG_WARN_TIME, 16000);
                       write_reg(mchw_pkg::REG_CRIT_TIME, 33000); end
      endcase
      if (ph == 2) hold_req = 1;
      random_phase(310);
      drain();
    end

    $display("ran %0d result words over six register settings and edge cases",
             results_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mchw_pkg.sv
sv/multi_channel_heartbeat_watchdog.sv
sv/mchw_checker.sv
verif/testbench.sv
